/* hw/rtl/brta_pkg.sv */
// shared types and constants of the bandgap ratio temperature averager
`default_nettype none

package brta_pkg;

  localparam int MUL_W  = 12;
  localparam int PROD_W = 2 * MUL_W;
  localparam int RD_W   = 10;
  localparam int DEN_W  = 20;
  localparam int MAG_W  = PROD_W + 4;
  localparam int CMP_W  = DEN_W + 9;
  localparam int Q_W    = 9;
  localparam int CNT_W  = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int SLOPE_W    = 10;

  localparam logic [CFG_IDX_W-1:0] REG_REF_MV    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MV = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 2'd2;

  localparam logic [MUL_W-1:0]   REF_MV_RESET    = 12'd1200;
  localparam logic [MUL_W-1:0]   OFFSET_MV_RESET = 12'd400;
  localparam logic [SLOPE_W-1:0] SLOPE_RESET     = 10'd195;

  localparam logic [CNT_W-1:0] DIV_LAST_BIT = 4'd8;
  localparam logic [CNT_W-1:0] AVG_LAST_BIT = 4'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_SCALE,
    ST_CHECK,
    ST_DIV,
    ST_ACC,
    ST_AVG,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [PROD_W-1:0] product;
    logic [CMP_W-1:0]  diff;
    logic              ge;
  } alu_out_t;

endpackage

`default_nettype wire

/* hw/rtl/brta_alu.sv */
// shared multiplier and trial subtractor of the averager
`default_nettype none

module brta_alu (
  input  wire logic [brta_pkg::MUL_W-1:0] mul_a,
  input  wire logic [brta_pkg::MUL_W-1:0] mul_b,
  input  wire logic [brta_pkg::CMP_W-1:0] rem,
  input  wire logic [brta_pkg::CMP_W-1:0] dsr,
  output brta_pkg::alu_out_t              res
);

  logic [brta_pkg::CMP_W:0] trial;

  assign trial       = {1'b0, rem} - {1'b0, dsr};
  assign res.product = brta_pkg::PROD_W'(mul_a) * brta_pkg::PROD_W'(mul_b);
  assign res.diff    = trial[brta_pkg::CMP_W-1:0];
  assign res.ge      = ~trial[brta_pkg::CMP_W];

endmodule

`default_nettype wire

/* hw/rtl/bandgap_ratio_temperature_average_unit.sv */
// top level of the bandgap ratio temperature averager
//
// input channel: in_valid / in_stall with action and reading. action 0 loads
// the bandgap reference reading and restarts a set. action 1 is a sensor
// sample: it goes through one shared 12x12 multiplier (three products), a
// scale step and a restoring divider that yields one quotient bit per cycle
// on one shared subtractor, and holds in_stall until the block is idle again
// (a bad reference skips to the accumulate step; a zero divisor or a quotient
// that reaches 512 skips the divider). the last sample of a set then runs the
// divider for the average and loads the output register in ST_OUT.
// output channel: out_valid / out_stall with temperature, sample_clamped and
// no_reference, one beat per SAMPLES samples. the output register holds the
// beat while out_stall is high; a finished set waits in ST_OUT until the
// register is free, and new samples are taken while a beat waits.
// config channel: cfg_valid / cfg_ready, always ready; the user writes it
// only when idle, and the block itself does not enforce it.
// reset (rst, synchronous): registers go to their defaults, no reference is
// loaded, the set is empty and out_valid drops.
`default_nettype none

module bandgap_ratio_temperature_average_unit #(
  parameter int ADC_BITS = 10,
  parameter int SAMPLES  = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [brta_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [brta_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                action,
  input  wire logic [9:0]                          reading,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [7:0]                               temperature,
  output logic                                     sample_clamped,
  output logic                                     no_reference
);

  localparam int SCNT_W = $clog2(SAMPLES + 1);
  localparam int SUM_W  = $clog2(255 * SAMPLES + SAMPLES / 2 + 1);
  localparam logic [brta_pkg::RD_W-1:0] ADC_MASK = brta_pkg::RD_W'((1 << ADC_BITS) - 1);
  localparam logic [brta_pkg::CMP_W-1:0] AVG_DSR = brta_pkg::CMP_W'(SAMPLES) << 7;
  localparam logic [brta_pkg::CMP_W-1:0] HALF    = brta_pkg::CMP_W'(SAMPLES / 2);

  brta_pkg::state_t state, state_next;
  brta_pkg::alu_out_t alu;

  logic [brta_pkg::MUL_W-1:0]   ref_mv;
  logic [brta_pkg::MUL_W-1:0]   offset_mv;
  logic [brta_pkg::SLOPE_W-1:0] slope;

  logic [brta_pkg::RD_W-1:0]  reference_reading;
  logic                       reference_bad;
  logic [SCNT_W-1:0]          samples_taken;
  logic [SUM_W-1:0]           degree_sum;
  logic                       clamp_seen;

  logic [brta_pkg::RD_W-1:0]   sample;
  logic [brta_pkg::PROD_W-1:0] prod;
  logic [brta_pkg::PROD_W-1:0] pa;
  logic signed [brta_pkg::PROD_W:0] diff;
  logic [brta_pkg::DEN_W-1:0]  den;
  logic                        neg;
  logic [brta_pkg::CMP_W-1:0]  rem;
  logic [brta_pkg::CMP_W-1:0]  dsr;
  logic [brta_pkg::Q_W-1:0]    q;
  logic [brta_pkg::CNT_W-1:0]  cnt;
  logic [7:0]                  deg;
  logic                        deg_clamp;

  logic [brta_pkg::MUL_W-1:0]  mul_a;
  logic [brta_pkg::MUL_W-1:0]  mul_b;
  logic                        in_accept;
  logic                        out_free;
  logic [brta_pkg::Q_W-1:0]    q_next;
  logic [SUM_W-1:0]            sum_next;
  logic [brta_pkg::PROD_W-1:0] diff_abs;
  logic                        last_sample;

  brta_alu u_alu (
    .mul_a (mul_a),
    .mul_b (mul_b),
    .rem   (rem),
    .dsr   (dsr),
    .res   (alu)
  );

  assign cfg_ready   = 1'b1;
  assign in_accept   = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign q_next      = {q[brta_pkg::Q_W-2:0], alu.ge};
  assign sum_next    = degree_sum + SUM_W'(deg);
  assign diff_abs    = diff[brta_pkg::PROD_W] ? brta_pkg::PROD_W'(-diff)
                                              : diff[brta_pkg::PROD_W-1:0];
  assign last_sample = (samples_taken == SCNT_W'(SAMPLES - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      brta_pkg::ST_IDLE: begin
        if (in_accept && action) begin
          state_next = reference_bad ? brta_pkg::ST_ACC : brta_pkg::ST_MUL_A;
        end
      end
      brta_pkg::ST_MUL_A: state_next = brta_pkg::ST_MUL_B;
      brta_pkg::ST_MUL_B: state_next = brta_pkg::ST_MUL_C;
      brta_pkg::ST_MUL_C: state_next = brta_pkg::ST_SCALE;
      brta_pkg::ST_SCALE: state_next = brta_pkg::ST_CHECK;
      brta_pkg::ST_CHECK: begin
        state_next = (den == '0 || alu.ge) ? brta_pkg::ST_ACC : brta_pkg::ST_DIV;
      end
      brta_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = brta_pkg::ST_ACC;
        end
      end
      brta_pkg::ST_ACC: state_next = last_sample ? brta_pkg::ST_AVG : brta_pkg::ST_IDLE;
      brta_pkg::ST_AVG: begin
        if (cnt == '0) begin
          state_next = brta_pkg::ST_OUT;
        end
      end
      brta_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = brta_pkg::ST_IDLE;
        end
      end
      default: state_next = brta_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      brta_pkg::ST_IDLE: in_stall = 1'b0;
      brta_pkg::ST_MUL_A: begin
        mul_a = ref_mv;
        mul_b = brta_pkg::MUL_W'(sample);
      end
      brta_pkg::ST_MUL_B: begin
        mul_a = offset_mv;
        mul_b = brta_pkg::MUL_W'(reference_reading);
      end
      brta_pkg::ST_MUL_C: begin
        mul_a = brta_pkg::MUL_W'(slope);
        mul_b = brta_pkg::MUL_W'(reference_reading);
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brta_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_mv    <= brta_pkg::REF_MV_RESET;
      offset_mv <= brta_pkg::OFFSET_MV_RESET;
      slope     <= brta_pkg::SLOPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        brta_pkg::REG_REF_MV:    ref_mv    <= cfg_data;
        brta_pkg::REG_OFFSET_MV: offset_mv <= cfg_data;
        brta_pkg::REG_SLOPE:     slope     <= cfg_data[brta_pkg::SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  // set state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_reading <= '0;
      reference_bad     <= 1'b1;
      samples_taken     <= '0;
      degree_sum        <= '0;
      clamp_seen        <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (state == brta_pkg::ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        brta_pkg::ST_IDLE: begin
          if (in_accept && !action) begin
            reference_reading <= reading & ADC_MASK;
            reference_bad     <= ((reading & ADC_MASK) == '0);
            samples_taken     <= '0;
            degree_sum        <= '0;
            clamp_seen        <= 1'b0;
          end
        end
        brta_pkg::ST_ACC: begin
          degree_sum    <= sum_next;
          clamp_seen    <= clamp_seen | deg_clamp;
          samples_taken <= samples_taken + SCNT_W'(1);
        end
        brta_pkg::ST_OUT: begin
          if (out_free) begin
            samples_taken <= '0;
            degree_sum    <= '0;
            clamp_seen    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk) begin
    case (state)
      brta_pkg::ST_IDLE: begin
        sample    <= reading & ADC_MASK;
        deg       <= '0;
        deg_clamp <= 1'b0;
      end
      brta_pkg::ST_MUL_A: prod <= alu.product;
      brta_pkg::ST_MUL_B: begin
        pa   <= prod;
        prod <= alu.product;
      end
      brta_pkg::ST_MUL_C: begin
        diff <= $signed({1'b0, pa}) - $signed({1'b0, prod});
        prod <= alu.product;
      end
      brta_pkg::ST_SCALE: begin
        den <= prod[brta_pkg::DEN_W-1:0];
        neg <= diff[brta_pkg::PROD_W];
        rem <= brta_pkg::CMP_W'((brta_pkg::MAG_W'(diff_abs) << 3)
                              + (brta_pkg::MAG_W'(diff_abs) << 1));
        dsr <= brta_pkg::CMP_W'(prod[brta_pkg::DEN_W-1:0]) << 9;
      end
      brta_pkg::ST_CHECK: begin
        q   <= '0;
        cnt <= brta_pkg::DIV_LAST_BIT;
        dsr <= dsr >> 1;
        if (den == '0) begin
          deg       <= (!neg && rem != '0) ? 8'd255 : 8'd0;
          deg_clamp <= (rem != '0);
        end else if (alu.ge) begin
          deg       <= neg ? 8'd0 : 8'd255;
          deg_clamp <= 1'b1;
        end
      end
      brta_pkg::ST_DIV: begin
        if (alu.ge) begin
          rem <= alu.diff;
        end
        q   <= q_next;
        dsr <= dsr >> 1;
        cnt <= cnt - brta_pkg::CNT_W'(1);
        if (cnt == '0) begin
          if (neg) begin
            deg       <= 8'd0;
            deg_clamp <= (q_next != '0);
          end else if (q_next[brta_pkg::Q_W-1]) begin
            deg       <= 8'd255;
            deg_clamp <= 1'b1;
          end else begin
            deg       <= q_next[7:0];
            deg_clamp <= 1'b0;
          end
        end
      end
      brta_pkg::ST_ACC: begin
        rem <= brta_pkg::CMP_W'(sum_next) + HALF;
        dsr <= AVG_DSR;
        q   <= '0;
        cnt <= brta_pkg::AVG_LAST_BIT;
      end
      brta_pkg::ST_AVG: begin
        if (alu.ge) begin
          rem <= alu.diff;
        end
        q   <= q_next;
        dsr <= dsr >> 1;
        cnt <= cnt - brta_pkg::CNT_W'(1);
      end
      brta_pkg::ST_OUT: begin
        if (out_free) begin
          temperature    <= q[brta_pkg::Q_W-1] ? 8'd255 : q[7:0];
          sample_clamped <= clamp_seen;
          no_reference   <= reference_bad;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/brta_checker.sv */
// port-level checks of the averager and their binding
`default_nettype none

module brta_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       action,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] temperature,
  input wire logic       no_reference
);

  // a stalled beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat after reset");

  // a sample keeps the block busy for the next cycle
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action |=> in_stall)
    else $error("sample accepted without going busy");

  // without a reference every sample counts zero degrees
  a_noref_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_reference |-> temperature == 8'd0)
    else $error("nonzero temperature without reference");

endmodule

bind bandgap_ratio_temperature_average_unit brta_checker u_brta_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .action       (action),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .temperature  (temperature),
  .no_reference (no_reference)
);

`default_nettype wire

/* tb/brta_tb_pkg.sv */
// testbench types shared by the stimulus and the temperature checker
`timescale 1ns / 1ps

package brta_tb_pkg;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  typedef struct packed {
    logic [7:0] temperature;
    logic       clamped;
    logic       no_ref;
  } temp_beat_t;

  localparam int SET_SIZE = 8;

endpackage

/* tb/brta_temperature_checker.sv */
// checker that predicts averaged temperatures and compares them with the output beats
`timescale 1ns / 1ps

module brta_temperature_checker
  import brta_pkg::*;
  import brta_tb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic                  action,
  input  wire logic [RD_W-1:0]       reading,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic [7:0]            temperature,
  input  wire logic                  sample_clamped,
  input  wire logic                  no_reference,
  output int                         fail_count,
  output int                         pending
);

  logic [MUL_W-1:0]   ref_mv;
  logic [MUL_W-1:0]   off_mv;
  logic [SLOPE_W-1:0] slope;
  logic [RD_W-1:0]    ref_rd;
  logic               ref_bad;
  int                 taken;
  logic [11:0]        deg_sum;
  logic               clamp_seen;
  temp_beat_t         expected_temps[$];
  int                 errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [7:0] degrees_of(input logic [RD_W-1:0] s, output logic clamped);
    longint num;
    longint den;
    longint q;
    clamped = 1'b0;
    if (ref_bad) return 8'd0;
    num = 10 * (longint'(ref_mv) * longint'(s) - longint'(off_mv) * longint'(ref_rd));
    den = longint'(slope) * longint'(ref_rd);
    if (den == 0) begin
      clamped = (num != 0);
      return (num > 0) ? 8'd255 : 8'd0;
    end
    q = num / den;
    if (q < 0) begin
      clamped = 1'b1;
      return 8'd0;
    end
    if (q > 255) begin
      clamped = 1'b1;
      return 8'd255;
    end
    return q[7:0];
  endfunction

  function automatic void advance_average(input logic act, input logic [RD_W-1:0] rd);
    logic       cl;
    logic [7:0] d;
    temp_beat_t b;
    if (act == ACT_LOAD) begin
      ref_rd     = rd;
      ref_bad    = (rd == '0);
      taken      = 0;
      deg_sum    = '0;
      clamp_seen = 1'b0;
      return;
    end
    d          = degrees_of(rd, cl);
    deg_sum    = deg_sum + d;
    clamp_seen = clamp_seen | cl;
    taken++;
    if (taken < SET_SIZE) return;
    b.temperature = 8'((deg_sum + SET_SIZE / 2) / SET_SIZE);
    b.clamped     = clamp_seen;
    b.no_ref      = ref_bad;
    expected_temps.push_back(b);
    taken      = 0;
    deg_sum    = '0;
    clamp_seen = 1'b0;
  endfunction

  function automatic void compare_temperature();
    temp_beat_t want;
    if (expected_temps.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected beat temperature=%0d clamped=%0b no_ref=%0b",
                 $time, temperature, sample_clamped, no_reference);
      return;
    end
    want = expected_temps.pop_front();
    if (temperature !== want.temperature || sample_clamped !== want.clamped ||
        no_reference !== want.no_ref) begin
      errors++;
      if (errors <= 10)
        $display("%0t: beat mismatch expected %0d/%0b/%0b got %0d/%0b/%0b", $time,
                 want.temperature, want.clamped, want.no_ref,
                 temperature, sample_clamped, no_reference);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      ref_mv     = REF_MV_RESET;
      off_mv     = OFFSET_MV_RESET;
      slope      = SLOPE_RESET;
      ref_rd     = '0;
      ref_bad    = 1'b1;
      taken      = 0;
      deg_sum    = '0;
      clamp_seen = 1'b0;
      expected_temps.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REF_MV:    ref_mv = cfg_data;
          REG_OFFSET_MV: off_mv = cfg_data;
          REG_SLOPE:     slope  = cfg_data[SLOPE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) compare_temperature();
      if (in_valid && !in_stall) advance_average(action, reading);
    end
    fail_count <= errors;
    pending    <= expected_temps.size();
  end

endmodule

/* tb/bandgap_ratio_temperature_average_unit_tb.sv */
// testbench top: stimulus, idling and verdict for the bandgap temperature averager
`timescale 1ns / 1ps

module bandgap_ratio_temperature_average_unit_tb;
  import brta_pkg::*;
  import brta_tb_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 500;
  localparam int IDLE_PCT      = 31;
  localparam int PHASE_BEATS   = 130;
  localparam int NUM_PHASES    = 6;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  action;
  logic [RD_W-1:0]       reading;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            temperature;
  logic                  sample_clamped;
  logic                  no_reference;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int beats_sent;
  int hold_left;
  bit hold_used;
  bit steady;
  bit hold_armed;

  logic [CFG_DATA_W-1:0] phase_ref   [NUM_PHASES] = '{12'd1200, 12'd4095, 12'd0,
                                                      12'd1, 12'd1, 12'd0};
  logic [CFG_DATA_W-1:0] phase_off   [NUM_PHASES] = '{12'd400, 12'd4095, 12'd0,
                                                      12'd0, 12'd4095, 12'd0};
  logic [CFG_DATA_W-1:0] phase_slope [NUM_PHASES] = '{12'd195, 12'hFFF, 12'd0,
                                                      12'd1, 12'd1, 12'd0};
  logic [RD_W-1:0] zero_slope_run [SET_SIZE] = '{10'd0, 10'd1, 10'd1023, 10'd1,
                                                 10'd1, 10'd1, 10'd1, 10'd1023};

  bandgap_ratio_temperature_average_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .reading        (reading),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .temperature    (temperature),
    .sample_clamped (sample_clamped),
    .no_reference   (no_reference)
  );

  brta_temperature_checker temp_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .reading        (reading),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .temperature    (temperature),
    .sample_clamped (sample_clamped),
    .no_reference   (no_reference),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // output side: random stall, one long hold-off that backs the block up
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic put_beat(input action_t act, input logic [RD_W-1:0] rd);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    reading  <= rd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_DATA_W-1:0] r, input logic [CFG_DATA_W-1:0] o,
                              input logic [CFG_DATA_W-1:0] s);
    write_reg(REG_REF_MV, r);
    write_reg(REG_OFFSET_MV, o);
    write_reg(REG_SLOPE, s);
    cfg_valid <= 1'b0;
  endtask

  // wait until every predicted beat is out and the block has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [RD_W-1:0] pick_reference();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 70) return RD_W'($urandom_range(20, 300));
    return RD_W'($urandom);
  endfunction

  function automatic logic [RD_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return RD_W'($urandom);
  endfunction

  task automatic run_random(input int target);
    int kind;
    int stop;
    stop = beats_sent + target;
    while (beats_sent < stop) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        put_beat(ACT_LOAD, pick_reference());
        repeat (SET_SIZE * $urandom_range(1, 2)) put_beat(ACT_SAMPLE, pick_sample());
      end else if (kind < 90) begin
        // set cut short by a reload
        repeat ($urandom_range(1, SET_SIZE - 1)) put_beat(ACT_SAMPLE, pick_sample());
        put_beat(ACT_LOAD, pick_reference());
      end else begin
        put_beat(action_t'($urandom_range(1)), RD_W'($urandom));
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    action     = ACT_LOAD;
    reading    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_REF_MV;
    cfg_data   = '0;
    steady     = 1'b0;
    hold_armed = 1'b0;
    beats_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // full set before any reference, then a zero reference and a partial set
    for (int i = 0; i < SET_SIZE; i++) put_beat(ACT_SAMPLE, {RD_W{i[0]}});
    put_beat(ACT_LOAD, '0);
    put_beat(ACT_SAMPLE, '0);
    put_beat(ACT_SAMPLE, '1);
    put_beat(ACT_SAMPLE, 10'd512);
    drain();

    // zero slope: positive, negative and zero numerators
    write_config(12'd1000, 12'd100, 12'hC00);
    put_beat(ACT_LOAD, 10'd10);
    for (int i = 0; i < SET_SIZE; i++) put_beat(ACT_SAMPLE, zero_slope_run[i]);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1)
        write_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      else
        write_config(phase_ref[p], phase_off[p], phase_slope[p]);
      steady     <= (p == 0);
      hold_armed <= (p == 1);
      run_random(PHASE_BEATS);
      drain();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
